// ----- hdl/gwi_pkg.sv -----
package gwi_pkg;

	localparam int DataWidth = 32;

	localparam logic [1:0] OpRead  = 2'd0;
	localparam logic [1:0] OpWrite = 2'd1;
	localparam logic [1:0] OpPin   = 2'd2;

	localparam logic [2:0] RegDir    = 3'd0;
	localparam logic [2:0] RegOut    = 3'd1;
	localparam logic [2:0] RegIn     = 3'd2;
	localparam logic [2:0] RegIe     = 3'd3;
	localparam logic [2:0] RegStatus = 3'd4;
	localparam logic [2:0] RegTrig   = 3'd5;
	localparam logic [2:0] RegPol    = 3'd6;

	typedef struct packed {
		logic [1:0]           op;
		logic [2:0]           reg_index;
		logic [DataWidth-1:0] write_data;
		logic [4:0]           pin_index;
	} gwi_req_t;

	typedef struct packed {
		logic [DataWidth-1:0] read_data;
		logic                 bad_access;
		logic                 irq_line;
		logic [DataWidth-1:0] pin_drive;
	} gwi_rsp_t;

endpackage

// ----- hdl/gwi_core.sv -----
module gwi_core import gwi_pkg::*; #(
	parameter int PIN_COUNT = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  gwi_req_t req,
	output gwi_rsp_t rsp
);

	localparam logic [DataWidth-1:0] PinMask = {DataWidth{1'b1}} >> (DataWidth - PIN_COUNT);

	logic [DataWidth-1:0] dir_q, out_q, in_q, ie_q, status_q, trig_q, pol_q, prev_q;
	logic [DataWidth-1:0] dir_d, out_d, in_d, ie_d, status_d, trig_d, pol_d, prev_d;
	logic [DataWidth-1:0] read_data;
	logic                 bad_access;

	// common status rule: level pins follow the match, edge pins latch on a matching edge
	function automatic logic [DataWidth-1:0] status_update(
		input logic [DataWidth-1:0] status,
		input logic [DataWidth-1:0] act,
		input logic [DataWidth-1:0] trig,
		input logic [DataWidth-1:0] pol,
		input logic [DataWidth-1:0] now,
		input logic [DataWidth-1:0] was
	);
		logic [DataWidth-1:0] lvl, edg, match, hit;
		lvl   = act & trig;
		edg   = act & ~trig;
		match = ~(now ^ pol);
		hit   = (~was & now & pol) | (was & ~now & ~pol);
		return (status & ~lvl) | (lvl & match) | (edg & hit);
	endfunction

	logic [DataWidth-1:0] pin_bit;
	logic [DataWidth-1:0] level_v;

	always_comb begin
		if ({1'b0, req.pin_index} < 6'(PIN_COUNT)) begin
			pin_bit = DataWidth'(1) << req.pin_index;
		end else begin
			pin_bit = '0;
		end
		level_v = {DataWidth{req.write_data[0]}};
	end

	always_comb begin
		dir_d      = dir_q;
		out_d      = out_q;
		in_d       = in_q;
		ie_d       = ie_q;
		status_d   = status_q;
		trig_d     = trig_q;
		pol_d      = pol_q;
		prev_d     = prev_q;
		read_data  = '0;
		bad_access = 1'b0;
		case (req.op)
			OpRead: begin
				case (req.reg_index)
					RegDir:    read_data = dir_q;
					RegOut:    read_data = out_q;
					RegIn:     read_data = ((dir_q & out_q) | (~dir_q & in_q)) & PinMask;
					RegIe:     read_data = ie_q;
					RegStatus: read_data = status_q;
					RegTrig:   read_data = trig_q;
					RegPol:    read_data = pol_q;
					default:   bad_access = 1'b1;
				endcase
			end
			OpWrite: begin
				case (req.reg_index)
					RegDir:    dir_d = req.write_data;
					RegOut:    out_d = req.write_data;
					RegIe:     ie_d = req.write_data;
					RegStatus: status_d = status_q & ~req.write_data;
					RegTrig:   trig_d = req.write_data;
					RegPol:    pol_d = req.write_data;
					default:   bad_access = 1'b1;
				endcase
				// enabled output pins re-evaluate against the output after the last write
				status_d = status_update(status_d, dir_d & ie_d & PinMask, trig_d, pol_d,
					out_d, prev_q);
				prev_d = out_d;
			end
			OpPin: begin
				in_d     = (in_q & ~pin_bit) | (level_v & pin_bit);
				status_d = status_update(status_q, ie_q & pin_bit, trig_q, pol_q,
					level_v, in_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= '0;
			out_q    <= '0;
			in_q     <= '0;
			ie_q     <= '0;
			status_q <= '0;
			trig_q   <= '0;
			pol_q    <= '0;
			prev_q   <= '0;
		end else if (fire) begin
			dir_q    <= dir_d;
			out_q    <= out_d;
			in_q     <= in_d;
			ie_q     <= ie_d;
			status_q <= status_d;
			trig_q   <= trig_d;
			pol_q    <= pol_d;
			prev_q   <= prev_d;
		end
	end

	assign rsp.read_data  = read_data;
	assign rsp.bad_access = bad_access;
	assign rsp.irq_line   = |status_d;
	assign rsp.pin_drive  = dir_d & out_d & PinMask;

endmodule

// ----- hdl/gpio_with_edge_level_interrupts.sv -----
// GPIO register bank with per-pin edge or level interrupts. Each request (bus read, bus
// write or pin level change) is taken into an input register, worked against the register
// bank and answered from a result register, so one request per cycle is sustained while
// results are not stalled. A result is registered when its request leaves the input register. The only
// limit is the downstream side: the input side stalls only while the input register is
// full and the held result is itself stalled. PIN_COUNT (1 to 32) sets how many pins take
// part in interrupts, input reads and pin drive; the registers stay 32 bits wide.
module gpio_with_edge_level_interrupts import gwi_pkg::*; #(
	parameter int PIN_COUNT = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  gwi_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output gwi_rsp_t rsp
);

	localparam logic [DataWidth-1:0] PinMask = {DataWidth{1'b1}} >> (DataWidth - PIN_COUNT);

	logic     valid_s1;
	gwi_req_t req_s1;
	logic     advance;
	logic     rsp_valid_q;
	gwi_rsp_t rsp_q;
	gwi_rsp_t rsp_d;

	// the held request moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	gwi_core #(
		.PIN_COUNT(PIN_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("request worked but no result held");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("input stalled without a stalled result");

	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((rsp_q.pin_drive & ~PinMask) == '0))
		else $error("pin drive outside the pin range");

	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.bad_access) |-> (rsp_q.read_data == '0))
		else $error("bad access returned read data");

endmodule

// ----- tb/sv/gpio_irq_checker.sv -----
module gpio_irq_checker import gwi_pkg::*; #(
	parameter int PIN_COUNT = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_stall,
	input  gwi_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  gwi_rsp_t rsp,
	output int       errors,
	output int       outstanding
);

	localparam logic [DataWidth-1:0] PinMask =
		(PIN_COUNT >= DataWidth) ? '1 : ((32'd1 << PIN_COUNT) - 32'd1);

	logic [DataWidth-1:0] dir_bits      = '0;
	logic [DataWidth-1:0] out_bits      = '0;
	logic [DataWidth-1:0] in_bits       = '0;
	logic [DataWidth-1:0] ie_bits       = '0;
	logic [DataWidth-1:0] status_bits   = '0;
	logic [DataWidth-1:0] trig_bits     = '0;
	logic [DataWidth-1:0] pol_bits      = '0;
	logic [DataWidth-1:0] last_out_bits = '0;

	gwi_rsp_t expected_gpio_rsp[$];
	int       mismatch_count = 0;

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] gpio check: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// works out the response to one request and moves the register bank on
	function automatic gwi_rsp_t gpio_response(input gwi_req_t r);
		gwi_rsp_t             res;
		logic [DataWidth-1:0] active, lvl_pins, edge_pins, match, hit, pin_bit;
		logic                 level, was_high, pol_high;
		res = '0;
		case (r.op)
			OpRead: begin
				case (r.reg_index)
					RegDir:    res.read_data = dir_bits;
					RegOut:    res.read_data = out_bits;
					RegIn:     res.read_data = ((dir_bits & out_bits) | (~dir_bits & in_bits)) & PinMask;
					RegIe:     res.read_data = ie_bits;
					RegStatus: res.read_data = status_bits;
					RegTrig:   res.read_data = trig_bits;
					RegPol:    res.read_data = pol_bits;
					default:   res.bad_access = 1'b1;
				endcase
			end
			OpWrite: begin
				case (r.reg_index)
					RegDir:    dir_bits = r.write_data;
					RegOut:    out_bits = r.write_data;
					RegIe:     ie_bits = r.write_data;
					RegStatus: status_bits = status_bits & ~r.write_data;
					RegTrig:   trig_bits = r.write_data;
					RegPol:    pol_bits = r.write_data;
					default:   res.bad_access = 1'b1;
				endcase
				// enabled output pins re-evaluate even after a rejected write
				active    = dir_bits & ie_bits & PinMask;
				lvl_pins  = active & trig_bits;
				edge_pins = active & ~trig_bits;
				match     = ~(out_bits ^ pol_bits);
				hit       = (~last_out_bits & out_bits & pol_bits) |
					(last_out_bits & ~out_bits & ~pol_bits);
				status_bits   = (status_bits & ~lvl_pins) | (lvl_pins & match) | (edge_pins & hit);
				last_out_bits = out_bits;
			end
			OpPin: begin
				if (r.pin_index < PIN_COUNT) begin
					pin_bit  = 32'd1 << r.pin_index;
					level    = r.write_data[0];
					was_high = |(in_bits & pin_bit);
					pol_high = |(pol_bits & pin_bit);
					in_bits  = level ? (in_bits | pin_bit) : (in_bits & ~pin_bit);
					if (|(ie_bits & pin_bit)) begin
						if (|(trig_bits & pin_bit)) begin
							status_bits = (level == pol_high) ? (status_bits | pin_bit)
								: (status_bits & ~pin_bit);
						end else if ((pol_high && !was_high && level) ||
							(!pol_high && was_high && !level)) begin
							status_bits = status_bits | pin_bit;
						end
					end
				end
			end
			default: ;
		endcase
		res.irq_line  = |status_bits;
		res.pin_drive = dir_bits & out_bits & PinMask;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : check_proc
		gwi_rsp_t want;
		if (!arst_n) begin
			dir_bits      = '0;
			out_bits      = '0;
			in_bits       = '0;
			ie_bits       = '0;
			status_bits   = '0;
			trig_bits     = '0;
			pol_bits      = '0;
			last_out_bits = '0;
			expected_gpio_rsp.delete();
			outstanding <= 0;
		end else begin
			// responses first: one accepted this edge belongs to an older request
			if (rsp_valid && !rsp_stall) begin
				if (expected_gpio_rsp.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = expected_gpio_rsp.pop_front();
					if (rsp.read_data !== want.read_data)
						report_mismatch($sformatf("read_data expected %h got %h",
							want.read_data, rsp.read_data));
					if (rsp.bad_access !== want.bad_access)
						report_mismatch($sformatf("bad_access expected %b got %b",
							want.bad_access, rsp.bad_access));
					if (rsp.irq_line !== want.irq_line)
						report_mismatch($sformatf("irq_line expected %b got %b",
							want.irq_line, rsp.irq_line));
					if (rsp.pin_drive !== want.pin_drive)
						report_mismatch($sformatf("pin_drive expected %h got %h",
							want.pin_drive, rsp.pin_drive));
				end
			end
			if (req_valid && !req_stall)
				expected_gpio_rsp.push_back(gpio_response(req));
			outstanding <= expected_gpio_rsp.size();
		end
		errors <= mismatch_count;
	end

endmodule

// ----- tb/sv/gpio_with_edge_level_interrupts_tb.sv -----
module gpio_with_edge_level_interrupts_tb;
	import gwi_pkg::*;

	localparam int PinCount    = 32;
	localparam int RandomItems = 1400;
	localparam int HoldCycles  = 80;

	localparam logic [1:0] OpUnused = 2'd3;
	localparam logic [2:0] RegNone  = 3'd7;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	gwi_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	gwi_rsp_t rsp;

	int   errors;
	int   outstanding;
	int   tx_idle_pct = 9;
	int   rx_idle_pct = 47;
	logic hold_rsp    = 1'b0;

	gpio_with_edge_level_interrupts #(
		.PIN_COUNT(PinCount)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	gpio_irq_checker #(
		.PIN_COUNT(PinCount)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	// response side: random stall, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_rsp  <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic gwi_req_t gpio_req(input logic [1:0] op, input logic [2:0] idx,
		input logic [31:0] data, input logic [4:0] pin);
		gwi_req_t r;
		r.op         = op;
		r.reg_index  = idx;
		r.write_data = data;
		r.pin_index  = pin;
		return r;
	endfunction

	task automatic send_req(input gwi_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		gwi_req_t    r;
		int          sel;
		logic [31:0] data;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(gpio_req(OpRead, RegDir, '0, '0));
		send_req(gpio_req(OpRead, RegIn, '0, '0));
		send_req(gpio_req(OpRead, RegNone, '1, '1));
		send_req(gpio_req(OpWrite, RegDir, '1, '0));
		send_req(gpio_req(OpWrite, RegIe, '1, '0));
		// falling polarity: the rising edge sets no status, the falling edge sets it
		send_req(gpio_req(OpWrite, RegOut, '1, '0));
		send_req(gpio_req(OpWrite, RegOut, '0, '1));
		send_req(gpio_req(OpRead, RegStatus, '0, '0));
		send_req(gpio_req(OpWrite, RegStatus, '1, '0));
		// low half level triggered, active high with outputs at zero
		send_req(gpio_req(OpWrite, RegTrig, 32'h0000_ffff, '0));
		send_req(gpio_req(OpWrite, RegPol, '1, '0));
		send_req(gpio_req(OpWrite, RegIn, 32'h1234_5678, '0));
		send_req(gpio_req(OpWrite, RegNone, '1, '1));
		send_req(gpio_req(OpUnused, RegNone, '1, '1));
		send_req(gpio_req(OpPin, RegDir, 32'h1, 5'd0));
		send_req(gpio_req(OpPin, RegNone, '1, 5'd31));
		send_req(gpio_req(OpPin, RegNone, '0, 5'd31));
		send_req(gpio_req(OpWrite, RegDir, 32'haaaa_aaaa, '0));
		send_req(gpio_req(OpPin, RegDir, 32'hffff_fffe, 5'd5));
		send_req(gpio_req(OpWrite, RegOut, 32'ha5a5_a5a5, '0));
		send_req(gpio_req(OpRead, RegIn, '0, '0));
		send_req(gpio_req(OpWrite, RegIe, '0, '0));
		send_req(gpio_req(OpPin, RegDir, 32'h1, 5'd7));
		send_req(gpio_req(OpRead, RegTrig, '0, '0));
		send_req(gpio_req(OpRead, RegPol, '0, '0));
		wait_drained();

		for (int i = 0; i < RandomItems; i++) begin
			if (i == RandomItems / 3) begin
				tx_idle_pct = 47;
				rx_idle_pct <= 9;
			end
			if (i == 2 * RandomItems / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			if (i == 100 || i == 1100)
				hold_rsp <= 1'b1;
			if (i == 600)
				wait_drained();

			case ($urandom_range(7))
				0:       data = '0;
				1:       data = '1;
				2:       data = 32'd1 << $urandom_range(31);
				default: data = $urandom;
			endcase
			r = gpio_req(OpRead, 3'($urandom_range(7)), data, 5'($urandom_range(31)));
			sel = $urandom_range(99);
			if (sel < 30) begin
				r.op = OpPin;
			end else if (sel < 62) begin
				r.op = OpWrite;
				// outputs written most, so edges keep coming
				case ($urandom_range(8))
					0:       r.reg_index = RegDir;
					1, 2, 3: r.reg_index = RegOut;
					4:       r.reg_index = RegIe;
					5:       r.reg_index = RegStatus;
					6:       r.reg_index = RegTrig;
					7:       r.reg_index = RegPol;
					default: r.reg_index = 3'($urandom_range(7));
				endcase
			end else if (sel >= 95) begin
				r.op = OpUnused;
			end
			send_req(r);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
